// File: rtl/ucs_pkg.sv
package ucs_pkg;

    // Widths fixed by the character format.
    localparam int unsigned CharBytes = 6;
    localparam int unsigned CharWidth = 8 * CharBytes;

    // Lead-byte classification masks and patterns.
    localparam logic [7:0] MaskTop1  = 8'h80;
    localparam logic [7:0] MaskTop2  = 8'hC0;
    localparam logic [7:0] MaskTop3  = 8'hE0;
    localparam logic [7:0] MaskTop4  = 8'hF0;
    localparam logic [7:0] MaskTop5  = 8'hF8;
    localparam logic [7:0] MaskTop6  = 8'hFC;
    localparam logic [7:0] MaskTop7  = 8'hFE;
    localparam logic [7:0] PatCont   = 8'h80;
    localparam logic [7:0] PatLead2  = 8'hC0;
    localparam logic [7:0] PatLead3  = 8'hE0;
    localparam logic [7:0] PatLead4  = 8'hF0;
    localparam logic [7:0] PatLead5  = 8'hF8;
    localparam logic [7:0] PatLead6  = 8'hFC;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CharWidth-1:0] char_bytes;
        logic [2:0]           char_length;
        t_status              status;
        logic                 matches_target;
        logic                 string_done;
        logic                 string_contains;
        logic                 last_of_run;
    } t_out_item;

    // One classified input item: an optional broken-character report
    // followed by an optional main result.
    typedef struct packed {
        logic                 brk;
        logic                 has_main;
        t_status              status;
        logic [CharWidth-1:0] char_bytes;
        logic [2:0]           char_length;
        logic                 eot;
    } t_job;

    // Character length announced by a lead byte, zero for a bad lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if ((b & MaskTop1) == 8'h00)     len = 3'd1;
        else if ((b & MaskTop3) == PatLead2)      len = 3'd2;
        else if ((b & MaskTop4) == PatLead3)      len = 3'd3;
        else if ((b & MaskTop5) == PatLead4)      len = 3'd4;
        else if ((b & MaskTop6) == PatLead5)      len = 3'd5;
        else if ((b & MaskTop7) == PatLead6)      len = 3'd6;
        else                                      len = 3'd0;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MaskTop2) == PatCont;
    endfunction

endpackage

// File: rtl/ucs_front.sv
module ucs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ucs_pkg::t_in_item i_item,
    output logic              o_job_valid,
    output ucs_pkg::t_job     o_job
);
    import ucs_pkg::*;

    logic [CharWidth-1:0] r_gath, n_gath;
    logic [2:0]           r_cnt, n_cnt;
    logic [2:0]           r_need, n_need;

    logic [7:0]           b;
    logic                 eot;
    logic                 in_char;
    logic [2:0]           lead_len;
    logic [CharWidth-1:0] app_gath;
    logic [2:0]           app_need;

    assign b        = i_item.data_byte;
    assign eot      = i_item.end_of_text;
    assign in_char  = (r_need != 3'd0) && (r_cnt >= 3'd1) && (r_cnt <= 3'd5);
    assign lead_len = lead_length(b);
    assign app_need = r_need - 3'd1;

    // Continuation byte dropped into the next free byte lane.
    always_comb begin
        app_gath = r_gath;
        for (int i = 0; i < CharBytes; i++) begin
            if (r_cnt == 3'(i)) begin
                app_gath[8*i +: 8] = b;
            end
        end
    end

    // Classify the byte and work out the next gathering state.
    always_comb begin
        o_job             = '0;
        o_job.status      = ST_OK;
        o_job.eot         = eot;
        n_gath            = '0;
        n_cnt             = 3'd0;
        n_need            = 3'd0;
        if (in_char && is_cont(b)) begin
            if (app_need == 3'd0) begin
                o_job.has_main    = 1'b1;
                o_job.char_bytes  = app_gath;
                o_job.char_length = r_cnt + 3'd1;
            end else if (eot) begin
                o_job.has_main = 1'b1;
                o_job.status   = ST_TRUNC;
            end else begin
                n_gath = app_gath;
                n_cnt  = r_cnt + 3'd1;
                n_need = app_need;
            end
        end else begin
            // A lead byte, possibly after an unfinished character.
            o_job.brk = in_char;
            if (lead_len == 3'd0) begin
                o_job.has_main = 1'b1;
                o_job.status   = ST_BAD_LEAD;
            end else if (lead_len == 3'd1) begin
                o_job.has_main    = 1'b1;
                o_job.char_bytes  = {{(CharWidth-8){1'b0}}, b};
                o_job.char_length = 3'd1;
            end else if (eot) begin
                o_job.has_main = 1'b1;
                o_job.status   = ST_TRUNC;
            end else begin
                n_gath = {{(CharWidth-8){1'b0}}, b};
                n_cnt  = 3'd1;
                n_need = lead_len - 3'd1;
            end
        end
        o_job_valid = i_accept && (o_job.brk || o_job.has_main);
    end

    // Gathering state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gath <= '0;
            r_cnt  <= 3'd0;
            r_need <= 3'd0;
        end else if (i_accept) begin
            r_gath <= n_gath;
            r_cnt  <= n_cnt;
            r_need <= n_need;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need != 3'd0) |-> (r_cnt >= 3'd1 && r_cnt <= 3'd5 && r_cnt + r_need <= 3'd6))
        else $error("gathering count out of range");

endmodule

// File: rtl/ucs_queue.sv
module ucs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ucs_pkg::t_job i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ucs_pkg::t_job o_data
);
    import ucs_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> (r_count == CW'(DEPTH)))
        else $error("queue count lost an entry while full");

endmodule

// File: rtl/ucs_back.sv
module ucs_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ucs_pkg::CharWidth-1:0]       i_cfg_data,
    input  logic                                i_job_valid,
    input  ucs_pkg::t_job                       i_job,
    output logic                                o_job_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output ucs_pkg::t_out_item                  o_out
);
    import ucs_pkg::*;

    logic [CharWidth-1:0] r_target;
    logic                 r_sub;
    logic                 r_fixed, r_value;
    logic                 r_ovalid;
    t_out_item            r_out;

    logic                 emit_brk;
    logic                 last;
    t_status              st;
    logic [CharWidth-1:0] bytes;
    logic [2:0]           len;
    logic                 hit;
    logic                 n_fixed, n_value;
    logic                 done;
    logic                 load;

    // Pick the result the head job owes next and score it.
    always_comb begin
        emit_brk = i_job.brk && !r_sub;
        last     = !emit_brk || !i_job.has_main;
        st       = emit_brk ? ST_BAD_CONT : i_job.status;
        bytes    = emit_brk ? '0 : i_job.char_bytes;
        len      = emit_brk ? 3'd0 : i_job.char_length;
        hit      = (st == ST_OK) && (bytes == r_target);
        n_fixed  = r_fixed || hit || (st != ST_OK);
        n_value  = r_fixed ? r_value : hit;
        done     = last && i_job.eot;
        load     = i_job_valid && (!r_ovalid || i_pop);
    end

    assign o_job_pop = load && last;
    assign o_empty   = !r_ovalid;
    assign o_out     = r_out;

    // Search target register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    // Sequencing and per-string verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub    <= 1'b0;
            r_fixed  <= 1'b0;
            r_value  <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_sub    <= !last;
            r_fixed  <= done ? 1'b0 : n_fixed;
            r_value  <= done ? 1'b0 : n_value;
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output item register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.char_bytes      <= bytes;
            r_out.char_length     <= len;
            r_out.status          <= st;
            r_out.matches_target  <= hit;
            r_out.string_done     <= done;
            r_out.string_contains <= done && n_fixed && n_value;
            r_out.last_of_run     <= last;
        end
    end

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.string_done) |-> o_out.last_of_run)
        else $error("string end reported before the last item of its byte");

    a_contains_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.string_contains) |-> o_out.string_done)
        else $error("verdict shown on an item that does not end the string");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.status != ST_OK) |->
            (o_out.char_length == 3'd0 && !o_out.matches_target))
        else $error("error item carries a character");

    a_verdict_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && done) |=> (!r_fixed && !r_value && !r_sub))
        else $error("verdict not cleared after string end");

endmodule

// File: rtl/utf8_char_splitter_search_unit.sv
// Groups a byte stream into UTF-8 characters of one to six bytes (old lead-byte
// rules) and flags each one that equals target_char, with a per-string verdict on
// the result that ends a string. One byte is accepted every clock cycle while full
// is low. Each byte yields zero, one or two result items; the result side delivers
// one item per cycle while its output is popped, so the extra item of a byte that
// breaks an unfinished character is absorbed by a QUEUE_DEPTH-entry job queue
// between the classifying front end and the result sequencer. A result passes
// through the job queue and then the output register before it reaches the
// output. Write target_char only while idle.
module utf8_char_splitter_search_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  ucs_pkg::t_in_item             i_in,
    output logic                          empty,
    input  logic                          pop,
    output ucs_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ucs_pkg::CharWidth-1:0] i_cfg_data
);
    import ucs_pkg::*;

    logic accept;
    logic job_valid;
    t_job job;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    ucs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    ucs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    ucs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

// File: tb/sv/tb.sv
module tb;
    import ucs_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned MAX_PRINTED  = 50;

    // One row of the directed table: either a target write or one input item,
    // optionally with the single result it must produce.
    typedef struct packed {
        logic                 is_cfg;
        logic [CharWidth-1:0] cfg_val;
        t_in_item             item;
        logic                 typed;
        t_out_item            want;
    } t_dir_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    t_in_item             in_item   = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CharWidth-1:0] cfg_data  = '0;

    // Model of the splitter state and its target register.
    logic [CharWidth-1:0] search_char;
    logic [CharWidth-1:0] cur_bytes;
    logic [2:0]           cur_count;
    logic [2:0]           cur_need;
    logic                 verdict_set;
    logic                 verdict_hit;

    t_out_item   step_chars[$];
    t_out_item   expected_chars[$];
    t_dir_row    dir_rows[$];
    int unsigned idle_pct    = 33;
    int unsigned tgt_len     = 1;
    int unsigned items_sent  = 0;
    int unsigned err_count   = 0;

    utf8_char_splitter_search_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_in        (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Run limit, far beyond the slowest legal run.
    initial begin
        #(LIMIT_CYCLES * 8);
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("MISMATCH: %s", msg);
        end
        err_count++;
    endtask

    // Length announced by a lead byte, zero when it cannot start a character.
    function automatic int unsigned char_len_of(input logic [7:0] b);
        int unsigned n;
        casez (b)
            8'b0???????: n = 1;
            8'b110?????: n = 2;
            8'b1110????: n = 3;
            8'b11110???: n = 4;
            8'b111110??: n = 5;
            8'b1111110?: n = 6;
            default:     n = 0;
        endcase
        return n;
    endfunction

    task automatic clear_char();
        cur_bytes = '0;
        cur_count = '0;
        cur_need  = '0;
    endtask

    // Records one character result and updates the string verdict.
    task automatic emit_char(input logic [CharWidth-1:0] bytes, input logic [2:0] len,
                             input t_status st);
        t_out_item r;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.char_bytes  = bytes;
            r.char_length = len;
        end
        r.matches_target = (st == ST_OK) && (bytes == search_char);
        if (!verdict_set) begin
            if (r.matches_target) begin
                verdict_set = 1'b1;
                verdict_hit = 1'b1;
            end else if (st != ST_OK) begin
                verdict_set = 1'b1;
                verdict_hit = 1'b0;
            end
        end
        step_chars.push_back(r);
    endtask

    task automatic take_lead(input logic [7:0] b, input logic eot);
        int unsigned n;
        n = char_len_of(b);
        if (n == 0) begin
            clear_char();
            emit_char('0, 3'd0, ST_BAD_LEAD);
        end else if (n == 1) begin
            clear_char();
            emit_char({40'b0, b}, 3'd1, ST_OK);
        end else begin
            cur_bytes = {40'b0, b};
            cur_count = 3'd1;
            cur_need  = 3'(n - 1);
            if (eot) begin
                clear_char();
                emit_char('0, 3'd0, ST_TRUNC);
            end
        end
    endtask

    // Works out the results caused by one accepted byte into step_chars.
    task automatic split_byte(input t_in_item it);
        logic [7:0]           b;
        logic [CharWidth-1:0] done_bytes;
        logic [2:0]           done_len;
        int unsigned          last;
        b = it.data_byte;
        step_chars.delete();
        if (cur_need != 0 && cur_count >= 1 && cur_count <= 5) begin
            if (b[7:6] == 2'b10) begin
                cur_bytes = cur_bytes | ({40'b0, b} << (8 * cur_count));
                cur_count = cur_count + 3'd1;
                cur_need  = cur_need - 3'd1;
                if (cur_need == 0) begin
                    done_bytes = cur_bytes;
                    done_len   = cur_count;
                    clear_char();
                    emit_char(done_bytes, done_len, ST_OK);
                end else if (it.end_of_text) begin
                    clear_char();
                    emit_char('0, 3'd0, ST_TRUNC);
                end
            end else begin
                // Broken character: report it, then treat the byte as a new lead.
                clear_char();
                emit_char('0, 3'd0, ST_BAD_CONT);
                take_lead(b, it.end_of_text);
            end
        end else begin
            take_lead(b, it.end_of_text);
        end
        if (step_chars.size() > 0) begin
            last = step_chars.size() - 1;
            step_chars[last].last_of_run = 1'b1;
            if (it.end_of_text) begin
                step_chars[last].string_done     = 1'b1;
                step_chars[last].string_contains = verdict_set && verdict_hit;
                clear_char();
                verdict_set = 1'b0;
                verdict_hit = 1'b0;
            end
        end
    endtask

    // Offers one item until it is accepted, idling at random in between.
    task automatic send_byte(input t_in_item it, input logic typed, input t_out_item want);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            if ($urandom_range(99) < idle_pct) begin
                push <= 1'b0;
            end else begin
                push    <= 1'b1;
                in_item <= it;
            end
            @(posedge clk);
            if (push && !full) begin
                taken = 1'b1;
                items_sent++;
                split_byte(it);
                if (typed) begin
                    expected_chars.push_back(want);
                end else begin
                    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
                end
            end
        end
    endtask

    // Stops sending and waits until the block has nothing left in flight.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [CharWidth-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        search_char = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] lead_for(input int unsigned len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       r[7]   = 1'b0;
            2:       r[7:5] = 3'b110;
            3:       r[7:4] = 4'b1110;
            4:       r[7:3] = 5'b11110;
            5:       r[7:2] = 6'b111110;
            default: r[7:1] = 7'b1111110;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [CharWidth-1:0] make_char(input int unsigned len);
        logic [CharWidth-1:0] ch;
        ch = '0;
        ch[7:0] = lead_for(len);
        for (int unsigned j = 1; j < len; j++) ch[8*j +: 8] = cont_byte();
        return ch;
    endfunction

    // One string: mostly well-formed characters, with target hits, noise,
    // broken characters, stray continuation bytes and a truncated ending now and then.
    task automatic send_random_string();
        logic [7:0]  sb[$];
        int unsigned n_chars;
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        t_in_item    it;
        n_chars = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        for (int unsigned i = 0; i < n_chars; i++) begin
            kind = $urandom_range(99);
            if (kind < 10 && tgt_len != 0) begin
                for (int unsigned j = 0; j < tgt_len; j++) sb.push_back(search_char[8*j +: 8]);
            end else if (kind < 72) begin
                len = $urandom_range(1, 6);
                sb.push_back(lead_for(len));
                for (int unsigned j = 1; j < len; j++) sb.push_back(cont_byte());
            end else if (kind < 82) begin
                sb.push_back(8'($urandom));
            end else if (kind < 92) begin
                len = $urandom_range(2, 6);
                cut = $urandom_range(0, len - 2);
                sb.push_back(lead_for(len));
                for (int unsigned j = 0; j < cut; j++) sb.push_back(cont_byte());
            end else begin
                sb.push_back(cont_byte());
            end
        end
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(2, 6);
            cut = $urandom_range(0, len - 2);
            sb.push_back(lead_for(len));
            for (int unsigned j = 0; j < cut; j++) sb.push_back(cont_byte());
        end
        for (int unsigned i = 0; i < sb.size(); i++) begin
            it.data_byte   = sb[i];
            it.end_of_text = (i == sb.size() - 1);
            send_byte(it, 1'b0, '0);
        end
    endtask

    // Compares one delivered result with the oldest expectation.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected result: bytes %h status %0d",
                                      got.char_bytes, got.status));
            return;
        end
        want = expected_chars.pop_front();
        if (got.char_bytes !== want.char_bytes)
            report_mismatch($sformatf("char_bytes %h, expected %h",
                                      got.char_bytes, want.char_bytes));
        if (got.char_length !== want.char_length)
            report_mismatch($sformatf("char_length %0d, expected %0d",
                                      got.char_length, want.char_length));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.matches_target !== want.matches_target)
            report_mismatch($sformatf("matches_target %b, expected %b",
                                      got.matches_target, want.matches_target));
        if (got.string_done !== want.string_done)
            report_mismatch($sformatf("string_done %b, expected %b",
                                      got.string_done, want.string_done));
        if (got.string_contains !== want.string_contains)
            report_mismatch($sformatf("string_contains %b, expected %b",
                                      got.string_contains, want.string_contains));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      got.last_of_run, want.last_of_run));
    endtask

    // Result side: random pops, checked at the edge that takes the item.
    always @(negedge clk) begin
        pop <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            check_result(out_item);
        end
    end

    function automatic t_dir_row byte_row(input logic [7:0] b, input logic eot);
        t_dir_row r;
        r = '0;
        r.item.data_byte   = b;
        r.item.end_of_text = eot;
        return r;
    endfunction

    function automatic t_dir_row known_row(input logic [7:0] b, input logic eot,
                                           input logic [CharWidth-1:0] bytes,
                                           input logic [2:0] len, input t_status st,
                                           input logic hit, input logic contains);
        t_dir_row r;
        r = byte_row(b, eot);
        r.typed                = 1'b1;
        r.want.char_bytes      = bytes;
        r.want.char_length     = len;
        r.want.status          = st;
        r.want.matches_target  = hit;
        r.want.string_done     = eot;
        r.want.string_contains = contains;
        r.want.last_of_run     = 1'b1;
        return r;
    endfunction

    function automatic t_dir_row target_row(input logic [CharWidth-1:0] v);
        t_dir_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    initial begin
        int unsigned end_count;
        int unsigned len;
        bit          pressure_done;

        search_char   = '0;
        verdict_set   = 1'b0;
        verdict_hit   = 1'b0;
        pressure_done = 1'b0;
        clear_char();

        // Directed table. With the reset target of zero a zero byte is a hit.
        dir_rows.push_back(known_row(8'h00, 1'b1, 48'h0,  3'd1, ST_OK,       1'b1, 1'b1));
        dir_rows.push_back(known_row(8'h80, 1'b1, 48'h0,  3'd0, ST_BAD_LEAD, 1'b0, 1'b0));
        dir_rows.push_back(known_row(8'hFF, 1'b1, 48'h0,  3'd0, ST_BAD_LEAD, 1'b0, 1'b0));
        dir_rows.push_back(known_row(8'hFE, 1'b0, 48'h0,  3'd0, ST_BAD_LEAD, 1'b0, 1'b0));
        dir_rows.push_back(known_row(8'h7F, 1'b1, 48'h7F, 3'd1, ST_OK,       1'b0, 1'b0));
        dir_rows.push_back(known_row(8'hC3, 1'b1, 48'h0,  3'd0, ST_TRUNC,    1'b0, 1'b0));
        // Two-byte target, then a three-byte character in the same string.
        dir_rows.push_back(target_row(48'h00_A9C3));
        dir_rows.push_back(byte_row(8'hC3, 1'b0));
        dir_rows.push_back(byte_row(8'hA9, 1'b0));
        dir_rows.push_back(byte_row(8'hE2, 1'b0));
        dir_rows.push_back(byte_row(8'h82, 1'b0));
        dir_rows.push_back(byte_row(8'hAC, 1'b1));
        // Four-byte lead broken by an ASCII byte that ends the string.
        dir_rows.push_back(byte_row(8'hF0, 1'b0));
        dir_rows.push_back(byte_row(8'h9F, 1'b0));
        dir_rows.push_back(byte_row(8'h41, 1'b1));
        // Five-byte lead cut off after one continuation byte.
        dir_rows.push_back(byte_row(8'hF8, 1'b0));
        dir_rows.push_back(byte_row(8'h88, 1'b1));
        // Longest character as target, then found.
        dir_rows.push_back(target_row(48'hBFBF_BFBF_BFFD));
        dir_rows.push_back(byte_row(8'hFD, 1'b0));
        for (int i = 0; i < 4; i++) dir_rows.push_back(byte_row(8'hBF, 1'b0));
        dir_rows.push_back(byte_row(8'hBF, 1'b1));
        // Broken character whose breaking byte is itself a bad lead.
        dir_rows.push_back(byte_row(8'hC2, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, 1'b1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_target(dir_rows[i].cfg_val);
            end else begin
                send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random phases, each with its own target setting.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    len = $urandom_range(1, 6);
                    write_target(make_char(len));
                    tgt_len = len;
                end
                1: begin
                    // All ones is no valid character; this phase also runs without idling.
                    write_target('1);
                    tgt_len  = 0;
                    idle_pct = 0;
                end
                2: begin
                    write_target('0);
                    tgt_len  = 1;
                    idle_pct = 33;
                end
                default: begin
                    len = $urandom_range(2, 3);
                    write_target(make_char(len));
                    tgt_len = len;
                end
            endcase
            end_count = items_sent + PHASE_ITEMS;
            while (items_sent < end_count) begin
                send_random_string();
                if (ph == 2 && !pressure_done && items_sent + PHASE_ITEMS / 2 > end_count) begin
                    drain();
                    pressure_done = 1'b1;
                end
            end
        end

        drain();
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
